FILE: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted-insert priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DefCapacity = 16;
  localparam int unsigned ValueW      = 16;
  localparam int unsigned PrioW       = 4;
  localparam int unsigned OccW        = 5;

  // op field codes
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DEQUEUED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } spq_status_e;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [PrioW-1:0]  prio;
  } spq_entry_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic load;  // state changes this cycle
    logic enq;   // 1: insert, 0: shift toward head
  } spq_cell_ctrl_t;

endpackage

FILE: rtl/spq_if.sv
// ----------------------------------------------------------------------------
// spq_in_if / spq_out_if
// Valid/ready channels carrying queue commands and queue responses.
// ----------------------------------------------------------------------------
interface spq_in_if;
  import spq_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic [ValueW-1:0] item_value;
  logic [PrioW-1:0]  item_priority;

  modport source (output valid, output op, output item_value, output item_priority,
                  input ready);
  modport sink   (input valid, input op, input item_value, input item_priority,
                  output ready);
endinterface

interface spq_out_if;
  import spq_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [ValueW-1:0] out_value;
  logic [PrioW-1:0]  out_priority;
  logic [OccW-1:0]   occupancy;

  modport source (output valid, output status, output out_value, output out_priority,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input out_value, input out_priority,
                  input occupancy, output ready);
endinterface

FILE: rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: compare against the incoming entry, then
// keep, take the new entry, or take a neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic           clk_i,
  input  spq_cell_ctrl_t ctrl_i,
  input  logic           valid_i,    // slot holds a live entry
  input  spq_entry_t     new_i,      // entry being inserted
  input  spq_entry_t     left_i,     // neighbor toward the head
  input  spq_entry_t     right_i,    // neighbor toward the tail
  input  logic           left_gt_i,  // neighbor outranks the new entry
  output logic           gt_o,
  output spq_entry_t     entry_o
);

  spq_entry_t entry_q, entry_d;

  assign gt_o    = valid_i && (entry_q.prio > new_i.prio);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.load) begin
      if (ctrl_i.enq) begin
        // new entry lands at the first slot it is not outranked by
        if (!gt_o) begin
          entry_d = left_gt_i ? new_i : left_i;
        end
      end else begin
        entry_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

FILE: rtl/sorted_insert_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue
// The response beat is registered and valid in the cycle after acceptance.
// One command per cycle if out ready; all cells compare and shift in parallel.
// Reset: count and output valid clear; slot contents are left unset.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  // ---- handshake ------------------------------------------------------------
  logic out_valid_q;
  logic in_fire;

  // Output register decouples the sides: take a new beat whenever the
  // pending response is gone or is leaving this cycle.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  // ---- occupancy ------------------------------------------------------------
  logic [CntW-1:0] count_q, count_d;
  logic            is_full, is_empty, is_enq;

  assign is_full  = (count_q == CntW'(CAPACITY));
  assign is_empty = (count_q == '0);
  assign is_enq   = (in_i.op == OP_ENQUEUE);

  // ---- cell chain -----------------------------------------------------------
  spq_cell_ctrl_t ctrl;
  spq_entry_t     new_entry;
  spq_entry_t     cell_entry [CAPACITY];
  logic [CAPACITY-1:0] cell_gt;
  logic [CAPACITY-1:0] cell_valid;

  assign new_entry.value = in_i.item_value;
  assign new_entry.prio  = in_i.item_priority;

  // Dropped enqueues and empty dequeues leave the chain untouched
  assign ctrl.enq  = is_enq;
  assign ctrl.load = in_fire && (is_enq ? !is_full : !is_empty);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_entry_t left_e, right_e;
    logic       left_gt;

    // slots below the count are live; the rest hold stale data
    assign cell_valid[i] = (count_q > CntW'(i));

    if (i == 0) begin : g_head
      assign left_e  = new_entry;
      assign left_gt = 1'b1;     // head always takes the entry if not outranked
    end else begin : g_body
      assign left_e  = cell_entry[i-1];
      assign left_gt = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_e = '0;       // vacated tail slot, never read
    end else begin : g_mid
      assign right_e = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .valid_i   (cell_valid[i]),
      .new_i     (new_entry),
      .left_i    (left_e),
      .right_i   (right_e),
      .left_gt_i (left_gt),
      .gt_o      (cell_gt[i]),
      .entry_o   (cell_entry[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.load) begin
      count_d = is_enq ? count_q + CntW'(1) : count_q - CntW'(1);
    end
  end

  // ---- response -------------------------------------------------------------
  spq_status_e       status_q, status_d;
  logic [ValueW-1:0] value_q, value_d;
  logic [PrioW-1:0]  prio_q, prio_d;

  always_comb begin
    value_d = '0;
    prio_d  = '0;
    if (is_enq) begin
      status_d = is_full ? ST_FULL : ST_ENQUEUED;
    end else if (is_empty) begin
      status_d = ST_EMPTY;
    end else begin
      status_d = ST_DEQUEUED;
      value_d  = cell_entry[0].value;
      prio_d   = cell_entry[0].prio;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload, no reset
  logic [CntW-1:0] occ_q;
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q <= status_d;
      value_q  <= value_d;
      prio_q   <= prio_d;
      occ_q    <= count_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = status_q;
  assign out_o.out_value    = value_q;
  assign out_o.out_priority = prio_q;
  assign out_o.occupancy    = OccW'(occ_q);

  // ---- checks ---------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_enq && is_full) |=> $stable(count_q))
    else $error("full enqueue changed the count");

  a_deq_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !is_enq && !is_empty) |=> (out_valid_q && status_q == ST_DEQUEUED))
    else $error("dequeue response missing");

  a_sorted_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CntW'(2)) |-> (cell_entry[0].prio >= cell_entry[1].prio))
    else $error("head entry out of order");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == ST_EMPTY) |-> (value_q == '0 && occ_q == '0))
    else $error("empty response carries data");

endmodule

FILE: tb/sv/sorted_insert_priority_queue_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue_test
// Drives enqueue/dequeue command beats into the sorted-insert priority queue
// and checks every response beat against a shadow copy of the slot array.
// Directed beats cover the empty, full, tie and extreme cases first. Random
// phases then push the queue toward full, toward empty or keep it balanced,
// with bursty input and a stalling response side.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue_test;
  import spq_pkg::*;

  localparam int unsigned Capacity   = DefCapacity;
  localparam int unsigned RandItems  = 1800;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainWait  = 8;

  // One expected response beat
  typedef struct {
    spq_status_e       status;
    logic [ValueW-1:0] value;
    logic [PrioW-1:0]  prio;
    logic [OccW-1:0]   occ;
  } spq_resp_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_BURSTY} rx_mode_e;
  typedef enum int {PRI_ANY, PRI_PAIR, PRI_EDGES} prio_mode_e;

  // --------------------------------------------------------------------------
  // Shadow queue: keeps its own sorted slot array, turns each accepted command
  // into the response it must cause, and checks responses in order.
  // --------------------------------------------------------------------------
  class spq_shadow;
    logic [ValueW-1:0] slot_val [Capacity];
    logic [PrioW-1:0]  slot_pri [Capacity];
    int unsigned       count;
    spq_resp_t         pending_resp [$];
    int unsigned       errors;
    int unsigned       n_enq, n_deq, n_full, n_empty, n_checked, peak;

    function new();
      count     = 0;
      errors    = 0;
      n_enq     = 0;
      n_deq     = 0;
      n_full    = 0;
      n_empty   = 0;
      n_checked = 0;
      peak      = 0;
    endfunction

    function int unsigned pending_count();
      return pending_resp.size();
    endfunction

    // Apply one accepted command to the shadow array and queue its response.
    function void note_command(logic op, logic [ValueW-1:0] v, logic [PrioW-1:0] p);
      spq_resp_t   r;
      int unsigned pos;
      int unsigned i;
      r.status = ST_ENQUEUED;
      r.value  = '0;
      r.prio   = '0;
      if (op == OP_ENQUEUE) begin
        if (count >= Capacity) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          // new entry goes ahead of the first one that is not strictly higher
          pos = 0;
          while (pos < count && slot_pri[pos] > p) pos++;
          for (i = count; i > pos; i--) begin
            slot_val[i] = slot_val[i-1];
            slot_pri[i] = slot_pri[i-1];
          end
          slot_val[pos] = v;
          slot_pri[pos] = p;
          count++;
          n_enq++;
          if (count > peak) peak = count;
        end
      end else if (count == 0) begin
        r.status = ST_EMPTY;
        n_empty++;
      end else begin
        r.status = ST_DEQUEUED;
        r.value  = slot_val[0];
        r.prio   = slot_pri[0];
        for (i = 0; i + 1 < count; i++) begin
          slot_val[i] = slot_val[i+1];
          slot_pri[i] = slot_pri[i+1];
        end
        count--;
        n_deq++;
      end
      r.occ = OccW'(count);
      pending_resp.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] spq mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_response(logic [1:0] st, logic [ValueW-1:0] v, logic [PrioW-1:0] p,
                        logic [OccW-1:0] occ);
      spq_resp_t e;
      if (pending_resp.size() == 0) begin
        report($sformatf("unexpected beat st=%0d val=%h pri=%0d occ=%0d", st, v, p, occ));
      end else begin
        e = pending_resp.pop_front();
        n_checked++;
        if ({st, v, p, occ} !== {e.status, e.value, e.prio, e.occ})
          report($sformatf("got st=%0d val=%h pri=%0d occ=%0d, want st=%0d val=%h pri=%0d occ=%0d",
                           st, v, p, occ, e.status, e.value, e.prio, e.occ));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels, DUT
  // --------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  spq_in_if  cmd_if ();
  spq_out_if rsp_if ();

  sorted_insert_priority_queue #(
    .CAPACITY (Capacity)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (rsp_if)
  );

  spq_shadow sb = new();

  int unsigned cycle_cnt = 0;

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  // Runaway guard: a hung handshake lands here.
  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("[%0t] timeout after %0d cycles, %0d responses pending",
             $realtime, cycle_cnt, sb.pending_count());
    $display("sorted_insert_priority_queue_test: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Response side: ready follows a pattern that switches between wide open,
  // random drops and long stall bursts, so stalls hit every queue state.
  // --------------------------------------------------------------------------
  logic        rx_ready  = 1'b0;
  rx_mode_e    rx_mode   = RX_OPEN;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;

  assign rsp_if.ready = rx_ready;

  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      rx_mode   <= rx_mode_e'($urandom_range(0, 2));
      mode_left <= $urandom_range(50, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (rx_mode)
      RX_OPEN: begin
        rx_ready <= 1'b1;
      end
      RX_RANDOM: begin
        rx_ready <= ($urandom_range(0, 9) < 7);
      end
      default: begin
        if (hold_left != 0) begin
          hold_left <= hold_left - 1;
          rx_ready  <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          hold_left <= $urandom_range(1, 12);
          rx_ready  <= 1'b0;
        end else begin
          rx_ready  <= 1'b1;
        end
      end
    endcase
  end

  // Monitor: a response beat moves when valid and ready meet at the edge.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
      sb.check_response(rsp_if.status, rsp_if.out_value, rsp_if.out_priority,
                        rsp_if.occupancy);
  end

  // --------------------------------------------------------------------------
  // Command side
  // --------------------------------------------------------------------------
  // Present one command beat and hold it until accepted. Back-to-back calls
  // keep valid high, so a burst never drops valid between beats.
  task automatic send_cmd(input logic op, input logic [ValueW-1:0] v,
                          input logic [PrioW-1:0] p);
    cmd_if.valid         <= 1'b1;
    cmd_if.op            <= op;
    cmd_if.item_value    <= v;
    cmd_if.item_priority <= p;
    do @(posedge clk_i); while (cmd_if.ready !== 1'b1);
    sb.note_command(op, v, p);
  endtask

  // Drop valid while idling; payload lines carry noise meanwhile.
  task automatic idle_cmd(input int unsigned n);
    cmd_if.valid         <= 1'b0;
    cmd_if.op            <= 1'($urandom);
    cmd_if.item_value    <= ValueW'($urandom);
    cmd_if.item_priority <= PrioW'($urandom);
    repeat (n) @(posedge clk_i);
  endtask

  initial begin
    int unsigned       k;
    int unsigned       burst_left;
    int unsigned       phase_left;
    int unsigned       enq_pct;
    prio_mode_e        pri_mode;
    logic [PrioW-1:0]  pri_a, pri_b;
    logic              op;
    logic [ValueW-1:0] v;
    logic [PrioW-1:0]  p;

    cmd_if.valid         = 1'b0;
    cmd_if.op            = OP_ENQUEUE;
    cmd_if.item_value    = '0;
    cmd_if.item_priority = '0;
    burst_left = 0;
    phase_left = 0;
    enq_pct    = 50;
    pri_mode   = PRI_ANY;
    pri_a      = '0;
    pri_b      = '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed ----
    // dequeue right after reset: empty status, payload ignored
    send_cmd(OP_DEQUEUE, 16'hFFFF, 4'hF);
    idle_cmd(2);
    // extremes, then ties at top, middle and bottom (newest must sit first)
    send_cmd(OP_ENQUEUE, 16'hFFFF, 4'hF);
    send_cmd(OP_ENQUEUE, 16'h0000, 4'h0);
    send_cmd(OP_ENQUEUE, 16'h1234, 4'h7);
    send_cmd(OP_ENQUEUE, 16'hABCD, 4'h7);
    send_cmd(OP_ENQUEUE, 16'h5555, 4'h7);
    send_cmd(OP_ENQUEUE, 16'hAAAA, 4'hF);
    send_cmd(OP_ENQUEUE, 16'h0001, 4'h0);
    send_cmd(OP_ENQUEUE, 16'h8000, 4'h8);
    send_cmd(OP_ENQUEUE, 16'h7FFF, 4'h6);
    // fill the rest of the slots
    for (k = 0; k < Capacity - 9; k++)
      send_cmd(OP_ENQUEUE, ValueW'(16'h1111 * (k + 1)), PrioW'(2 * k + 1));
    // full: this one is dropped
    send_cmd(OP_ENQUEUE, 16'hFFFF, 4'hF);
    // head removal with shift-up, payload on dequeue set to zero
    for (k = 0; k < 5; k++)
      send_cmd(OP_DEQUEUE, '0, '0);

    // ---- random phases ----
    for (k = 0; k < RandItems; k++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(60, 200);
        case ($urandom_range(0, 2))
          0:       enq_pct = 85;   // push toward full
          1:       enq_pct = 15;   // drain toward empty
          default: enq_pct = 50;
        endcase
        pri_mode = prio_mode_e'($urandom_range(0, 2));
        pri_a    = PrioW'($urandom);
        pri_b    = PrioW'($urandom);
      end
      phase_left--;

      if (burst_left == 0) begin
        idle_cmd($urandom_range(1, 8));
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                 : $urandom_range(1, 40);
      end
      burst_left--;

      op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
      case ($urandom_range(0, 15))
        0:       v = '0;
        1:       v = '1;
        default: v = ValueW'($urandom);
      endcase
      case (pri_mode)
        PRI_PAIR:  p = $urandom_range(0, 1) ? pri_a : pri_b;  // heavy ties
        PRI_EDGES: p = $urandom_range(0, 1) ? '1 : '0;
        default:   p = PrioW'($urandom);
      endcase
      send_cmd(op, v, p);
    end

    // ---- drain ----
    idle_cmd(1);
    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (sb.pending_count() != 0)
      sb.report($sformatf("%0d responses never arrived", sb.pending_count()));

    $display("covered %0d enqueues, %0d dequeues, %0d full drops, %0d empty dequeues",
             sb.n_enq, sb.n_deq, sb.n_full, sb.n_empty);
    $display("checked %0d responses, peak occupancy %0d of %0d",
             sb.n_checked, sb.peak, Capacity);
    if (sb.errors == 0) begin
      $display("sorted_insert_priority_queue_test: done, clean");
    end else begin
      $display("sorted_insert_priority_queue_test: done, errors");
    end
    $finish;
  end

endmodule
